FILE: hdl/mexp_pkg.sv
// shared types and constants for the modular exponentiation block
// operand width, sequencer counter width and the modular multiplier request/response structs
// no dependencies
`default_nettype none

package mexp_pkg;

    // operand width of the arithmetic; the i/o fields stay at FIELD_W
    localparam int OPERAND_WIDTH = 32;
    localparam int FIELD_W       = 32;
    localparam int CNT_W         = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;
    localparam int STEP_W        = OPERAND_WIDTH + 2;

    typedef logic [OPERAND_WIDTH-1:0] t_operand;
    typedef logic [CNT_W-1:0]         t_count;

    // request to the modular multiplier: computes (a * b) mod m
    typedef struct packed {
        logic     start;
        t_operand a;
        t_operand b;
        t_operand m;
    } t_mm_req;

    // response from the modular multiplier
    typedef struct packed {
        logic     done;
        t_operand product;
    } t_mm_rsp;

endpackage

`default_nettype wire

FILE: hdl/mexp_mulmod_unit.sv
// iterative interleaved modular multiplier, one multiplier bit per cycle, msb first
// acc = (2 * acc + bit * a) mod m, reduced by a compare against m and 2m
// depends on mexp_pkg
`default_nettype none

module mexp_mulmod_unit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire mexp_pkg::t_mm_req i_req,
    output mexp_pkg::t_mm_rsp     o_rsp
);
    import mexp_pkg::*;

    localparam t_count LAST_BIT = CNT_W'(OPERAND_WIDTH - 1);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    t_count             r_cnt, n_cnt;
    t_operand           r_acc, n_acc;
    t_operand           r_a, n_a;
    t_operand           r_b, n_b;
    t_operand           r_m, n_m;

    logic [STEP_W-1:0]  sum;
    logic [STEP_W-1:0]  m1;
    logic [STEP_W-1:0]  m2;
    logic [STEP_W-1:0]  reduced;

    // one reduction step; sum stays below 3m
    always_comb begin
        sum = (STEP_W'(r_acc) << 1) + (r_b[OPERAND_WIDTH-1] ? STEP_W'(r_a) : '0);
        m1  = STEP_W'(r_m);
        m2  = STEP_W'(r_m) << 1;
        priority if (sum >= m2) begin
            reduced = sum - m2;
        end else if (sum >= m1) begin
            reduced = sum - m1;
        end else begin
            reduced = sum;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_m    = r_m;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_acc  = '0;
            n_a    = i_req.a;
            n_b    = i_req.b;
            n_m    = i_req.m;
        end else if (r_busy) begin
            n_acc = OPERAND_WIDTH'(reduced);
            n_b   = r_b << 1;
            n_cnt = r_cnt + t_count'(1);
            if (r_cnt == LAST_BIT) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_m   <= n_m;
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

endmodule

`default_nettype wire

FILE: hdl/modular_exponentiation.sv
// modular exponentiation: base ^ exponent mod modulus, right-to-left square-and-multiply
// steps: the base is first reduced mod m, then per exponent bit a multiply when it is set
//   and a square; a zero modulus goes straight to the output register
// throughput: one request at a time, set by the bit-serial modular multiplier (1 bit/cycle)
// reset: synchronous active-low i_rst_n clears the sequencer and the output valid
// depends on mexp_pkg and mexp_mulmod_unit
`default_nettype none

module modular_exponentiation (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // request channel
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [mexp_pkg::FIELD_W-1:0] i_base_value,
    input  wire logic [mexp_pkg::FIELD_W-1:0] i_exponent_value,
    input  wire logic [mexp_pkg::FIELD_W-1:0] i_modulus_value,
    // result channel
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [mexp_pkg::FIELD_W-1:0]   o_power_result,
    output logic                           o_bad_modulus
);
    import mexp_pkg::*;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,  // waiting for a request
        S_REDUCE = 6'b000010,  // base mod modulus on the multiplier
        S_BIT    = 6'b000100,  // look at the current exponent bit
        S_MUL    = 6'b001000,  // result = result * base mod m
        S_SQR    = 6'b010000,  // base = base * base mod m
        S_FINISH = 6'b100000   // hand the result to the output register
    } t_state;

    localparam t_count LAST_CNT = CNT_W'(OPERAND_WIDTH - 1);

    t_state    r_state, n_state;
    t_operand  r_res, n_res;    // running result
    t_operand  r_base, n_base;  // running base power
    t_operand  r_exp, n_exp;    // exponent bits still to scan
    t_operand  r_mod, n_mod;
    t_count    r_cnt, n_cnt;    // index of the current exponent bit
    logic      r_bad, n_bad;

    // output register, parts the result side from the sequencer
    logic      r_out_valid, n_out_valid;
    t_operand  r_out_res, n_out_res;
    logic      r_out_bad, n_out_bad;

    t_mm_req   mm_req;
    t_mm_rsp   mm_rsp;

    t_operand  in_base, in_exp, in_mod;
    logic      in_accept;
    logic      out_free;

    // operands masked to the arithmetic width
    assign in_base = OPERAND_WIDTH'(i_base_value);
    assign in_exp  = OPERAND_WIDTH'(i_exponent_value);
    assign in_mod  = OPERAND_WIDTH'(i_modulus_value);

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    // output slot is free when empty or being drained this cycle
    assign out_free   = !r_out_valid || !i_out_stall;

    mexp_mulmod_unit u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mm_req),
        .o_rsp   (mm_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        n_base      = r_base;
        n_exp       = r_exp;
        n_mod       = r_mod;
        n_cnt       = r_cnt;
        n_bad       = r_bad;
        n_out_valid = r_out_valid;
        n_out_res   = r_out_res;
        n_out_bad   = r_out_bad;
        mm_req      = '0;

        // result taken by the consumer
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_exp = in_exp;
                    n_mod = in_mod;
                    n_cnt = '0;
                    if (in_mod == '0) begin
                        // zero modulus: flag it, result fixed at zero
                        n_bad   = 1'b1;
                        n_res   = '0;
                        n_state = S_FINISH;
                    end else begin
                        // result starts at 1 mod m, zero for a modulus of one
                        n_bad   = 1'b0;
                        n_res   = (in_mod == OPERAND_WIDTH'(1)) ? '0 : OPERAND_WIDTH'(1);
                        // base mod m as (1 * base) mod m, base scanned msb first
                        mm_req.start = 1'b1;
                        mm_req.a     = OPERAND_WIDTH'(1);
                        mm_req.b     = in_base;
                        mm_req.m     = in_mod;
                        n_state      = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                if (mm_rsp.done) begin
                    n_base  = mm_rsp.product;
                    n_state = S_BIT;
                end
            end
            S_BIT: begin
                priority if (r_exp == '0) begin
                    n_state = S_FINISH;
                end else if (r_exp[0]) begin
                    // set bit: multiply into the result
                    mm_req.start = 1'b1;
                    mm_req.a     = r_res;
                    mm_req.b     = r_base;
                    mm_req.m     = r_mod;
                    n_state      = S_MUL;
                end else if (r_cnt == LAST_CNT) begin
                    // last exponent bit done, the final square is not needed
                    n_state = S_FINISH;
                end else begin
                    // move to the next bit and square the base
                    n_exp        = r_exp >> 1;
                    n_cnt        = r_cnt + t_count'(1);
                    mm_req.start = 1'b1;
                    mm_req.a     = r_base;
                    mm_req.b     = r_base;
                    mm_req.m     = r_mod;
                    n_state      = S_SQR;
                end
            end
            S_MUL: begin
                if (mm_rsp.done) begin
                    n_res   = mm_rsp.product;
                    // bit consumed; next pass through S_BIT does the square
                    n_exp   = {r_exp[OPERAND_WIDTH-1:1], 1'b0};
                    n_state = S_BIT;
                end
            end
            S_SQR: begin
                if (mm_rsp.done) begin
                    n_base  = mm_rsp.product;
                    n_state = S_BIT;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_res   = r_res;
                    n_out_bad   = r_bad;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_res     <= n_res;
        r_base    <= n_base;
        r_exp     <= n_exp;
        r_mod     <= n_mod;
        r_cnt     <= n_cnt;
        r_bad     <= n_bad;
        r_out_res <= n_out_res;
        r_out_bad <= n_out_bad;
    end

    assign o_out_valid    = r_out_valid;
    assign o_power_result = FIELD_W'(r_out_res);
    assign o_bad_modulus  = r_out_bad;

endmodule

`default_nettype wire

FILE: dv/tb_modular_exponentiation.sv
// self-checking testbench for modular_exponentiation: directed corner requests, then random
// requests under three idling phases and one long result hold-off, checked by a scoreboard
// depends on mexp_pkg and the modular_exponentiation rtl
`default_nettype none

module tb_modular_exponentiation;

    localparam int W = mexp_pkg::FIELD_W;

    // predicts base ^ exponent mod modulus and checks each result in order
    class power_scoreboard;
        typedef struct {
            logic [W-1:0] power;
            logic         bad;
        } t_power_want;

        t_power_want expected_powers[$];
        int          mismatches = 0;

        // right-to-left square-and-multiply with 64-bit products, exact for 32-bit operands
        function logic [W-1:0] power_mod(logic [W-1:0] b, logic [W-1:0] e, logic [W-1:0] m);
            logic [63:0] acc;
            logic [63:0] sq;
            logic [63:0] mm;
            mm  = {32'd0, m};
            acc = 64'd1 % mm;
            sq  = {32'd0, b} % mm;
            for (int i = 0; i < W; i++) begin
                if (e[i]) begin
                    acc = (acc * sq) % mm;
                end
                sq = (sq * sq) % mm;
            end
            return acc[W-1:0];
        endfunction

        function void note_request(logic [W-1:0] b, logic [W-1:0] e, logic [W-1:0] m);
            t_power_want want;
            if (m == '0) begin
                want.power = '0;
                want.bad   = 1'b1;
            end else begin
                want.power = power_mod(b, e, m);
                want.bad   = 1'b0;
            end
            expected_powers.push_back(want);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_result(logic [W-1:0] power, logic bad);
            t_power_want want;
            if (expected_powers.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: power=%h bad=%b",
                                          power, bad));
                return;
            end
            want = expected_powers.pop_front();
            if (power !== want.power) begin
                report_mismatch($sformatf("power_result got %h want %h", power, want.power));
            end
            if (bad !== want.bad) begin
                report_mismatch($sformatf("bad_modulus got %b want %b", bad, want.bad));
            end
        endtask

        function int pending();
            return expected_powers.size();
        endfunction

        task flush_leftovers();
            while (expected_powers.size() != 0) begin
                t_power_want want;
                want = expected_powers.pop_front();
                report_mismatch($sformatf("no result for expected power=%h bad=%b",
                                          want.power, want.bad));
            end
        endtask
    endclass

    // dut inputs, all known from time zero
    logic         i_clk            = 1'b0;
    logic         i_rst_n          = 1'b0;
    logic         i_in_valid       = 1'b0;
    logic         o_in_stall;
    logic [W-1:0] i_base_value     = '0;
    logic [W-1:0] i_exponent_value = '0;
    logic [W-1:0] i_modulus_value  = '0;
    logic         o_out_valid;
    logic         i_out_stall      = 1'b0;
    logic [W-1:0] o_power_result;
    logic         o_bad_modulus;

    // idling percentages per phase, set by the stimulus process
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // long result hold-off: the stimulus bumps the ask count, the receiver does the counting
    int hold_off_asks = 0;
    int hold_off_seen = 0;
    int hold_off_left = 0;

    power_scoreboard sb = new();

    modular_exponentiation dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_base_value     (i_base_value),
        .i_exponent_value (i_exponent_value),
        .i_modulus_value  (i_modulus_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_power_result   (o_power_result),
        .o_bad_modulus    (o_bad_modulus)
    );

    // 10 time unit clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver side: random stall, or a long hold-off when one is asked for
    always @(posedge i_clk) begin
        if (hold_off_asks != hold_off_seen) begin
            hold_off_seen <= hold_off_asks;
            hold_off_left <= 4000;
            i_out_stall   <= 1'b1;
        end else if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            i_out_stall   <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // monitor: handshakes seen with pre-edge values, request noted before result checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_request(i_base_value, i_exponent_value, i_modulus_value);
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_power_result, o_bad_modulus);
            end
        end
    end

    // offer one request and hold it until accepted; valid stays high into the next request
    // unless the sender idles, so valid never gets two assignments in one step
    task automatic send_request(input logic [W-1:0] b, input logic [W-1:0] e,
                                input logic [W-1:0] m);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < tx_idle_pct) begin
                @(posedge i_clk);
            end
        end
        i_in_valid       <= 1'b1;
        i_base_value     <= b;
        i_exponent_value <= e;
        i_modulus_value  <= m;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    // random requests; most exponents are short to keep the run time sane,
    // a quarter span all 32 bits so every exponent bit toggles
    task automatic run_phase(input int tx_pct, input int rx_pct, input int count,
                             input int hold_at);
        logic [W-1:0] b;
        logic [W-1:0] e;
        logic [W-1:0] m;
        int           pick;
        int           len;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) begin
                hold_off_asks++;
            end
            // modulus: zero, one, small, top bit set, or anything
            pick = $urandom_range(99);
            if (pick < 4)       m = '0;
            else if (pick < 8)  m = 32'd1;
            else if (pick < 20) m = $urandom_range(255, 2);
            else if (pick < 30) m = $urandom | 32'h8000_0000;
            else                m = $urandom;
            // base: zero, all ones, one below the modulus, or anything
            pick = $urandom_range(99);
            if (pick < 8)                  b = '0;
            else if (pick < 14)            b = '1;
            else if (pick < 20 && m != '0) b = m - 1;
            else                           b = $urandom;
            // exponent: zero, full width, or a short random bit length
            pick = $urandom_range(99);
            if (pick < 5) begin
                e = '0;
            end else if (pick < 30) begin
                e = $urandom;
            end else begin
                len = $urandom_range(10, 1);
                e   = $urandom & ((32'd1 << len) - 1);
            end
            send_request(b, e, m);
        end
    endtask

    initial begin
        tx_idle_pct = 21;
        rx_idle_pct = 68;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero modulus is flagged whatever the other operands
        send_request(32'd0, 32'd0, 32'd0);
        send_request('1, '1, 32'd0);
        send_request(32'd7, 32'd3, 32'd0);
        // modulus of one gives zero, also with a zero exponent
        send_request(32'd5, 32'd0, 32'd1);
        send_request('1, '1, 32'd1);
        // zero exponent gives one, so 0^0 is one for a modulus above one
        send_request(32'd0, 32'd0, 32'd7);
        send_request(32'd123, 32'd0, '1);
        // zero base with a nonzero exponent
        send_request(32'd0, 32'd5, 32'd13);
        send_request(32'd0, '1, '1);
        // all-ones operands and large moduli above 2^31
        send_request('1, '1, '1);
        send_request('1, 32'd1, '1);
        send_request(32'd2, '1, '1);
        send_request(32'hFFFF_FFFE, 32'd2, '1);
        send_request(32'hDEAD_BEEF, 32'h0000_FFFF, 32'hFFFF_FFFB);
        send_request(32'h8000_0000, '1, 32'h8000_0001);
        // base above the modulus, exponent of one, power of two modulus
        send_request(32'd1000, 32'd3, 32'd7);
        send_request(32'd12345, 32'd1, 32'd1000);
        send_request(32'd3, 32'd1, 32'd2);
        send_request(32'd2, 32'd31, 32'h8000_0000);
        send_request(32'd2, 32'd30, 32'h8000_0001);
        send_request(32'd1, '1, 32'd97);

        run_phase(21, 68, 610, -1);
        run_phase(68, 21, 610, -1);
        // no idling, and one long hold-off so the block fills and stalls its input
        run_phase(0, 0, 610, 50);
        i_in_valid <= 1'b0;

        // drain, then allow a worst-case latency for stray results
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (2300) @(posedge i_clk);
        sb.flush_leftovers();

        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog, far above the slowest correct run
    initial begin
        #300000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
